// ===== hdl/lbpo_pkg.sv =====
// Package for the bilinear offset-table pixel corrector.
// Holds table sizes, field widths, command and register codes, and the blend helper.
// Has no dependencies; the top level imports it.
package lbpo_pkg;

	// Table and sample sizes.
	localparam int NODE_COUNT    = 256;
	localparam int LEVEL_COUNT   = 8;
	localparam int CHANNEL_COUNT = 3;
	localparam int SAMPLE_BITS   = 12;

	// Field widths of the stream words.
	localparam int CMD_W   = 1;
	localparam int CHAN_W  = 2;
	localparam int FL_W    = 7;
	localparam int LEVEL_W = 3;
	localparam int NODE_W  = 8;
	localparam int VALUE_W = 16;
	localparam int FRAC_W  = 4;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// The table is split into four banks by level parity and node parity.
	localparam int NODE_HALF  = (NODE_COUNT + 1) / 2;
	localparam int LEVEL_HALF = (LEVEL_COUNT + 1) / 2;
	localparam int NH_W       = (NODE_HALF > 1) ? $clog2(NODE_HALF) : 1;
	localparam int LH_W       = (LEVEL_HALF > 1) ? $clog2(LEVEL_HALF) : 1;
	localparam int BANK_COUNT = 4;
	localparam int BANK_DEPTH = CHANNEL_COUNT * LEVEL_HALF * NODE_HALF;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);

	// Arithmetic widths after the interpolation.
	localparam int OFF_W      = VALUE_W + 1;
	localparam int SUM_W      = (SAMPLE_BITS + 1 > OFF_W) ? SAMPLE_BITS + 2 : OFF_W + 1;
	localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
	localparam int BLEND_W    = VALUE_W + FRAC_W + 2;

	// Item commands carried in tuser.
	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE = 1'b0,
		CMD_WRITE  = 1'b1
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE = 1'b0,
		REG_ZERO   = 1'b1
	} reg_idx_t;

	// Address of one entry inside a bank.
	function automatic logic [BANK_AW-1:0] bank_addr(
		input logic [CHAN_W-1:0] ch,
		input logic [LH_W-1:0]   lh,
		input logic [NH_W-1:0]   nh
	);
		return BANK_AW'((int'(ch) * LEVEL_HALF + int'(lh)) * NODE_HALF + int'(nh));
	endfunction

	// Weighted mix of two offsets with a 4-bit fraction, divided by 16 and
	// rounded half away from zero.
	function automatic logic signed [VALUE_W-1:0] blend4(
		input logic signed [VALUE_W-1:0] a,
		input logic signed [VALUE_W-1:0] b,
		input logic [FRAC_W-1:0]         f
	);
		logic signed [FRAC_W+1:0]  wa;
		logic signed [FRAC_W+1:0]  wb;
		logic signed [BLEND_W-1:0] sum;
		logic signed [BLEND_W-1:0] adj;
		wb  = signed'({2'b00, f});
		wa  = signed'((FRAC_W + 2)'(1 << FRAC_W)) - wb;
		sum = BLEND_W'(a) * BLEND_W'(wa) + BLEND_W'(b) * BLEND_W'(wb);
		// Negative values get one less so that the flooring shift rounds their ties away from zero.
		adj = sum + (sum[BLEND_W-1] ? BLEND_W'(7) : BLEND_W'(8));
		return adj[FRAC_W+VALUE_W-1:FRAC_W];
	endfunction

endpackage

// ===== hdl/lut_bilinear_pixel_offset_top.sv =====
// Top level of the bilinear offset-table pixel corrector.
// Holds the four table banks, the correction pipeline and the configuration registers.
// Depends on lbpo_pkg.
//
// Usage:
// The slave stream carries one word per item. tuser selects the command: a sample
// word is corrected, a write word stores one signed entry in the offset table of its
// channel. Write words produce no output word. Each output word carries the corrected
// sample and its channel.
// The configuration port sets the enable and the zero offset; write it only while no
// word is in flight.
// Pipeline: a sample word passes four register stages (table read, row blend, level
// blend with zero offset, add and clamp) before it is offered at the master side.
// Throughput: one word per clock unless the receiver stalls. The table is split by
// level and node parity into four banks, each read once per cycle, so all four corner
// entries come out together.
// Reset clears the enable, the zero offset and all valid bits; the table is not cleared
// and entries must be written before they are used.
// When the receiver stalls, each stage holds its word and tready drops only once every
// stage up to the input is full; no word is lost or repeated.
module lut_bilinear_pixel_offset_top
	import lbpo_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Slave stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// color_channel[1:0], pixel_sample[13:2], level_code[20:14], entry_level[23:21],
	// entry_node[31:24], entry_value[47:32]
	input  logic [IN_W-1:0]       s_tdata,
	// cmd[0]
	input  logic [CMD_W-1:0]      s_tuser,
	// Master stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// corrected_sample[11:0], out_channel[13:12], zero padding[15:14]
	output logic [OUT_W-1:0]      m_tdata,
	// Configuration port.
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Input field unpacking.
	logic [CHAN_W-1:0]          in_chan;
	logic [SAMPLE_BITS-1:0]     in_sample;
	logic [FL_W-1:0]            in_fl;
	logic [LEVEL_W-1:0]         in_elevel;
	logic [NODE_W-1:0]          in_enode;
	logic [VALUE_W-1:0]         in_evalue;
	logic                       in_acc;

	assign in_chan   = s_tdata[1:0];
	assign in_sample = s_tdata[13:2];
	assign in_fl     = s_tdata[20:14];
	assign in_elevel = s_tdata[23:21];
	assign in_enode  = s_tdata[31:24];
	assign in_evalue = s_tdata[47:32];

	// Configuration registers.
	logic                      enable_q;
	logic signed [VALUE_W-1:0] zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			zero_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_ZERO:   zero_q   <= signed'(cfg_data[VALUE_W-1:0]);
				default:    ;
			endcase
		end
	end

	// Stage handshake: a stage takes a new word when it is empty or its word moves on.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !valid_s4 || m_tready;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign s_tready = rdy1;
	assign in_acc   = s_tvalid && rdy1;

	// Node and level pair of the incoming sample, saturated at the table edge.
	logic [NODE_W-1:0]  n0, n1;
	logic [LEVEL_W-1:0] l0, l1;
	logic [CHAN_W-1:0]  rd_ch;
	logic [NH_W-1:0]    nh_even, nh_odd;
	logic [LH_W-1:0]    lh_even, lh_odd;

	always_comb begin
		n0 = (int'(in_sample[SAMPLE_BITS-1:FRAC_W]) > NODE_COUNT - 1)
			? NODE_W'(NODE_COUNT - 1) : NODE_W'(in_sample[SAMPLE_BITS-1:FRAC_W]);
		n1 = (n0 == NODE_W'(NODE_COUNT - 1)) ? n0 : n0 + NODE_W'(1);
		l0 = (int'(in_fl[FL_W-1:FRAC_W]) > LEVEL_COUNT - 1)
			? LEVEL_W'(LEVEL_COUNT - 1) : LEVEL_W'(in_fl[FL_W-1:FRAC_W]);
		l1 = (l0 == LEVEL_W'(LEVEL_COUNT - 1)) ? l0 : l0 + LEVEL_W'(1);
		rd_ch = (int'(in_chan) < CHANNEL_COUNT) ? in_chan : CHAN_W'(CHANNEL_COUNT - 1);
		// The even-index neighbor sits at (n0 + 1) / 2, the odd one at n0 / 2.
		nh_odd  = NH_W'(n0[NODE_W-1:1]);
		nh_even = (int'(n0[NODE_W-1:1]) + int'(n0[0]) > NODE_HALF - 1)
			? NH_W'(NODE_HALF - 1) : NH_W'(int'(n0[NODE_W-1:1]) + int'(n0[0]));
		lh_odd  = LH_W'(l0[LEVEL_W-1:1]);
		lh_even = (int'(l0[LEVEL_W-1:1]) + int'(l0[0]) > LEVEL_HALF - 1)
			? LH_W'(LEVEL_HALF - 1) : LH_W'(int'(l0[LEVEL_W-1:1]) + int'(l0[0]));
	end

	// Table write decode; out-of-range writes are dropped.
	logic                  wr_en;
	logic [1:0]            wr_bank;
	logic [BANK_AW-1:0]    wr_addr;

	assign wr_en   = in_acc && (cmd_t'(s_tuser) == CMD_WRITE)
		&& (int'(in_chan) < CHANNEL_COUNT) && (int'(in_elevel) < LEVEL_COUNT)
		&& (int'(in_enode) < NODE_COUNT);
	assign wr_bank = {in_elevel[0], in_enode[0]};
	assign wr_addr = bank_addr(in_chan, LH_W'(in_elevel[LEVEL_W-1:1]),
		NH_W'(in_enode[NODE_W-1:1]));

	// Four table banks, indexed by {level parity, node parity}; read data is stage 1.
	logic [VALUE_W-1:0] rd_s1 [BANK_COUNT];

	for (genvar b = 0; b < BANK_COUNT; b++) begin : g_bank
		localparam int LP = b / 2;
		localparam int NP = b % 2;
		logic [VALUE_W-1:0] mem [BANK_DEPTH];
		logic [BANK_AW-1:0] rd_addr;

		assign rd_addr = bank_addr(rd_ch, (LP == 1) ? lh_odd : lh_even,
			(NP == 1) ? nh_odd : nh_even);

		always_ff @(posedge clk) begin
			if (wr_en && (wr_bank == 2'(b))) begin
				mem[wr_addr] <= in_evalue;
			end
			if (rdy1) begin
				rd_s1[b] <= mem[rd_addr];
			end
		end
	end

	// Valid bits: only sample words enter the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_acc && (cmd_t'(s_tuser) == CMD_SAMPLE);
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Stage 1 payload: sample, channel, fractions and neighbor parities.
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [CHAN_W-1:0]      chan_s1;
	logic [FRAC_W-1:0]      nf_s1, lf_s1;
	logic                   n0p_s1, n1p_s1, l0p_s1, l1p_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sample_s1 <= in_sample;
			chan_s1   <= in_chan;
			nf_s1     <= in_sample[FRAC_W-1:0];
			lf_s1     <= in_fl[FRAC_W-1:0];
			n0p_s1    <= n0[0];
			n1p_s1    <= n1[0];
			l0p_s1    <= l0[0];
			l1p_s1    <= l1[0];
		end
	end

	// Stage 2: pick the four corners and blend along the nodes.
	logic signed [VALUE_W-1:0] q00, q01, q10, q11;
	logic [SAMPLE_BITS-1:0]    sample_s2;
	logic [CHAN_W-1:0]         chan_s2;
	logic [FRAC_W-1:0]         lf_s2;
	logic signed [VALUE_W-1:0] a0_s2, a1_s2;

	always_comb begin
		q00 = signed'(rd_s1[{l0p_s1, n0p_s1}]);
		q01 = signed'(rd_s1[{l0p_s1, n1p_s1}]);
		q10 = signed'(rd_s1[{l1p_s1, n0p_s1}]);
		q11 = signed'(rd_s1[{l1p_s1, n1p_s1}]);
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			sample_s2 <= sample_s1;
			chan_s2   <= chan_s1;
			lf_s2     <= lf_s1;
			a0_s2     <= blend4(q00, q01, nf_s1);
			a1_s2     <= blend4(q10, q11, nf_s1);
		end
	end

	// Stage 3: blend along the levels and remove the zero offset.
	logic signed [VALUE_W-1:0] lvl_mix;
	logic [SAMPLE_BITS-1:0]    sample_s3;
	logic [CHAN_W-1:0]         chan_s3;
	logic signed [OFF_W-1:0]   off_s3;

	assign lvl_mix = blend4(a0_s2, a1_s2, lf_s2);

	always_ff @(posedge clk) begin
		if (rdy3) begin
			sample_s3 <= sample_s2;
			chan_s3   <= chan_s2;
			off_s3    <= OFF_W'(lvl_mix) - OFF_W'(zero_q);
		end
	end

	// Stage 4: add to the sample and clamp, or pass the sample through.
	logic signed [SUM_W-1:0] sum;
	logic [SAMPLE_BITS-1:0]  clamped;
	logic [SAMPLE_BITS-1:0]  res_s4;
	logic [CHAN_W-1:0]       chan_s4;

	always_comb begin
		sum = signed'(SUM_W'(sample_s3)) + SUM_W'(off_s3);
		priority if (sum < 0) begin
			clamped = '0;
		end else if (sum > SUM_W'(SAMPLE_MAX)) begin
			clamped = SAMPLE_BITS'(SAMPLE_MAX);
		end else begin
			clamped = sum[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			res_s4  <= enable_q ? clamped : sample_s3;
			chan_s4 <= chan_s3;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {(OUT_W - SAMPLE_BITS - CHAN_W)'(0), chan_s4, res_s4};

`ifndef NO_ASSERTIONS
	// A write word never becomes a pipeline word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (cmd_t'(s_tuser) == CMD_WRITE)) |=> !valid_s1)
		else $error("write word entered the correction pipeline");

	// A stalled stage 3 word is kept until stage 4 can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !rdy4) |=> (valid_s3 && $stable(sample_s3) && $stable(off_s3)))
		else $error("stage 3 word lost during a stall");

	// With correction off, the sample reaches the output unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && rdy4 && !enable_q) |=> (m_tdata[SAMPLE_BITS-1:0] == $past(sample_s3)))
		else $error("pass-through sample was modified");
`endif

endmodule

// ===== bench/lut_bilinear_pixel_offset_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the bilinear offset-table pixel corrector.
// Fills the table nodes that samples use, runs a directed table of words, then random
// segments under new settings. Depends on lbpo_pkg and lut_bilinear_pixel_offset_top.
module lut_bilinear_pixel_offset_top_tb;
	import lbpo_pkg::*;

	localparam int PIPE_DEPTH  = 4;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SEG_COUNT   = 7;
	localparam int SEG_WORDS   = 120;
	localparam int DIR_N       = 24;
	localparam int FILL_N      = 8;
	localparam int BASE_N      = 5;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// color_channel, pixel_sample, level_code, entry_level, entry_node, entry_value
	logic [IN_W-1:0]       s_tdata;
	// cmd
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// corrected_sample, out_channel, zero padding
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lut_bilinear_pixel_offset_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// One corrected sample as it should leave the block.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [CHAN_W-1:0]      chan;
	} pixel_result_t;

	typedef enum logic {
		ROW_WORD,
		ROW_CFG
	} row_kind_t;

	// One row of the directed table: a stream word or a register write.
	typedef struct packed {
		row_kind_t              kind;
		cmd_t                   cmd;
		reg_idx_t               ridx;
		logic [CHAN_W-1:0]      chan;
		logic [SAMPLE_BITS-1:0] pixel;
		logic [FL_W-1:0]        level;
		logic [LEVEL_W-1:0]     e_lv;
		logic [NODE_W-1:0]      e_nd;
		logic [VALUE_W-1:0]     e_val;
		logic                   typed;
		logic [SAMPLE_BITS-1:0] exp_sample;
	} dir_row_t;

	// Directed part: pass-through after reset, extreme entries, extreme zero settings,
	// the out-of-range channel on samples and on writes, and the saturating top corner.
	dir_row_t dir_rows [DIR_N] = '{
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd0, 12'h000, 7'h00, 3'd0, 8'd0, 16'h0000, 1'b1, 12'h000},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd1, 12'hFFF, 7'h7F, 3'd0, 8'd0, 16'h0000, 1'b1, 12'hFFF},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd3, 12'hA5A, 7'h55, 3'd7, 8'hFF, 16'hFFFF, 1'b1, 12'hA5A},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd2, 12'h5A5, 7'h2A, 3'd5, 8'h5A, 16'h5A5A, 1'b1, 12'h5A5},
		'{ROW_WORD, CMD_WRITE,  REG_ENABLE, 2'd0, 12'h000, 7'h00, 3'd0, 8'd0, 16'h7FFF, 1'b0, 12'h000},
		'{ROW_WORD, CMD_WRITE,  REG_ENABLE, 2'd0, 12'h000, 7'h00, 3'd0, 8'd1, 16'h7FFF, 1'b0, 12'h000},
		'{ROW_WORD, CMD_WRITE,  REG_ENABLE, 2'd0, 12'h000, 7'h00, 3'd1, 8'd0, 16'h7FFF, 1'b0, 12'h000},
		'{ROW_WORD, CMD_WRITE,  REG_ENABLE, 2'd0, 12'h000, 7'h00, 3'd1, 8'd1, 16'h7FFF, 1'b0, 12'h000},
		'{ROW_WORD, CMD_WRITE,  REG_ENABLE, 2'd1, 12'hFFF, 7'h7F, 3'd7, 8'hFF, 16'h8000, 1'b0, 12'h000},
		'{ROW_WORD, CMD_WRITE,  REG_ENABLE, 2'd3, 12'h000, 7'h00, 3'd0, 8'd0, 16'h8000, 1'b0, 12'h000},
		'{ROW_CFG,  CMD_SAMPLE, REG_ENABLE, 2'd0, 12'h000, 7'h00, 3'd0, 8'd0, 16'h0001, 1'b0, 12'h000},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd0, 12'h000, 7'h00, 3'd0, 8'd0, 16'h0000, 1'b1, 12'hFFF},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd0, 12'h00F, 7'h0F, 3'd0, 8'd0, 16'h0000, 1'b1, 12'hFFF},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd1, 12'hFFF, 7'h7F, 3'd0, 8'd0, 16'h0000, 1'b1, 12'h000},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd3, 12'h800, 7'h40, 3'd0, 8'd0, 16'h0000, 1'b0, 12'h000},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd2, 12'hFF0, 7'h70, 3'd0, 8'd0, 16'h0000, 1'b0, 12'h000},
		'{ROW_CFG,  CMD_SAMPLE, REG_ZERO,   2'd0, 12'h000, 7'h00, 3'd0, 8'd0, 16'h8000, 1'b0, 12'h000},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd0, 12'h000, 7'h00, 3'd0, 8'd0, 16'h0000, 1'b1, 12'hFFF},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd2, 12'h123, 7'h31, 3'd0, 8'd0, 16'h0000, 1'b0, 12'h000},
		'{ROW_CFG,  CMD_SAMPLE, REG_ZERO,   2'd0, 12'h000, 7'h00, 3'd0, 8'd0, 16'h7FFF, 1'b0, 12'h000},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd0, 12'h000, 7'h00, 3'd0, 8'd0, 16'h0000, 1'b1, 12'h000},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd1, 12'hFFF, 7'h7F, 3'd0, 8'd0, 16'h0000, 1'b1, 12'h000},
		'{ROW_WORD, CMD_SAMPLE, REG_ENABLE, 2'd3, 12'h7FF, 7'h1F, 3'd0, 8'd0, 16'h0000, 1'b0, 12'h000},
		'{ROW_CFG,  CMD_SAMPLE, REG_ZERO,   2'd0, 12'h000, 7'h00, 3'd0, 8'd0, 16'h0000, 1'b0, 12'h000}
	};

	// Table nodes that are filled, and the lower nodes of the pairs that samples use.
	// Every pair starts at a filled node and ends at a filled node or saturates.
	int fill_nodes [FILL_N] = '{0, 1, 18, 19, 127, 128, 129, 255};
	int pair_bases [BASE_N] = '{0, 18, 127, 128, 255};

	// Shadow of the block state: settings and the offset table.
	logic                      enable_q;
	int                        zero_q;
	logic signed [VALUE_W-1:0] offset_mem [CHANNEL_COUNT][LEVEL_COUNT][NODE_COUNT];

	pixel_result_t pending_results [$];

	int send_idle_pct;
	int stall_pct;
	int cycle_count;
	int mismatch_count;
	int results_seen;
	int samples_sent;
	int words_written;
	int reg_writes;

	// Weighted mix of two offsets with a 4-bit weight, divided by 16, ties away from zero.
	function automatic int mix_round16(input int a, input int b, input int f);
		int s;
		s = a * (16 - f) + b * f;
		return (s >= 0) ? (s + 8) / 16 : (s - 8) / 16;
	endfunction

	// Expected corrected sample for one sample word under the current settings.
	function automatic logic [SAMPLE_BITS-1:0] correct_sample(
		input logic [CHAN_W-1:0]      chan,
		input logic [SAMPLE_BITS-1:0] pixel,
		input logic [FL_W-1:0]        level
	);
		int ch, l0, l1, n0, n1, lf, nf, row0, row1, off, px, res;
		px  = pixel;
		res = px;
		if (enable_q) begin
			ch = chan;
			if (ch > CHANNEL_COUNT - 1)
				ch = CHANNEL_COUNT - 1;
			l0 = int'(level) >> FRAC_W;
			n0 = px >> FRAC_W;
			if (l0 > LEVEL_COUNT - 1)
				l0 = LEVEL_COUNT - 1;
			if (n0 > NODE_COUNT - 1)
				n0 = NODE_COUNT - 1;
			l1 = (l0 + 1 < LEVEL_COUNT) ? l0 + 1 : LEVEL_COUNT - 1;
			n1 = (n0 + 1 < NODE_COUNT) ? n0 + 1 : NODE_COUNT - 1;
			lf = int'(level) & 'h0F;
			nf = px & 'h0F;
			row0 = mix_round16(offset_mem[ch][l0][n0], offset_mem[ch][l0][n1], nf);
			row1 = mix_round16(offset_mem[ch][l1][n0], offset_mem[ch][l1][n1], nf);
			off  = mix_round16(row0, row1, lf) - zero_q;
			res  = px + off;
			if (res < 0)
				res = 0;
			if (res > SAMPLE_MAX)
				res = SAMPLE_MAX;
		end
		return res[SAMPLE_BITS-1:0];
	endfunction

	// Table entry values: mostly small so that corrections stay inside the sample range.
	function automatic logic [VALUE_W-1:0] rand_offset();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return VALUE_W'($urandom_range(256)) - VALUE_W'(128);
		else if (pick < 75)
			return VALUE_W'($urandom_range(4095)) - VALUE_W'(2048);
		else if (pick < 95)
			return VALUE_W'($urandom);
		else if (pick < 98)
			return 16'h7FFF;
		else
			return 16'h8000;
	endfunction

	// Records the word in the shadow state, queues its result, then sends it.
	// Called at a rising edge; returns at the edge where the word was taken.
	task automatic issue_word(
		input cmd_t                   cmd,
		input logic [CHAN_W-1:0]      chan,
		input logic [SAMPLE_BITS-1:0] pixel,
		input logic [FL_W-1:0]        level,
		input logic [LEVEL_W-1:0]     elv,
		input logic [NODE_W-1:0]      enode,
		input logic [VALUE_W-1:0]     evalue,
		input logic                   typed,
		input logic [SAMPLE_BITS-1:0] typed_sample
	);
		pixel_result_t want;
		int            gap;
		if (cmd == CMD_WRITE) begin
			words_written++;
			if (chan < CHANNEL_COUNT && elv < LEVEL_COUNT && enode < NODE_COUNT)
				offset_mem[chan][elv][enode] = evalue;
		end else begin
			want.sample = typed ? typed_sample : correct_sample(chan, pixel, level);
			want.chan   = chan;
			pending_results.push_back(want);
			samples_sent++;
		end
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(9, 1);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {evalue, enode, elv, level, pixel, chan};
		// Outputs are settled at the falling edge; the word is taken at the next rise.
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Register write once the pipeline has emptied, including trailing table writes.
	task automatic set_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		reg_writes++;
		if (idx == REG_ENABLE)
			enable_q = val[0];
		else
			zero_q = $signed(val[VALUE_W-1:0]);
	endtask

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run-length guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Receiver: ready drops in random bursts while stall_pct is nonzero.
	initial begin
		int n;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
				n = $urandom_range(9, 1);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Output checker: each word taken at the master side against the oldest expectation.
	always @(negedge clk) begin : check_out
		pixel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected output word %h", m_tdata);
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (m_tdata[SAMPLE_BITS-1:0] !== want.sample ||
						m_tdata[SAMPLE_BITS+CHAN_W-1:SAMPLE_BITS] !== want.chan) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d: expected sample %0d chan %0d, got sample %0d chan %0d",
							results_seen, want.sample, want.chan, m_tdata[SAMPLE_BITS-1:0],
							m_tdata[SAMPLE_BITS+CHAN_W-1:SAMPLE_BITS]);
				end
			end
		end
	end

	// Main sequence.
	initial begin
		dir_row_t               row;
		cmd_t                   cmd;
		logic [CHAN_W-1:0]      chan;
		logic [SAMPLE_BITS-1:0] pixel;
		logic [FL_W-1:0]        level;
		logic [NODE_W-1:0]      enode;
		logic [CFG_DATA_W-1:0]  zval;
		logic                   en;
		int                     i;
		int                     seg;
		int                     pick;

		arst_n    = 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_SAMPLE;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_ENABLE;
		cfg_data  <= '0;
		enable_q  = 1'b0;
		zero_q    = 0;
		send_idle_pct = 10;
		stall_pct     = 10;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the used nodes of every channel and level, so no sample reads an
		// unwritten entry.
		for (int c = 0; c < CHANNEL_COUNT; c++)
			for (int l = 0; l < LEVEL_COUNT; l++)
				for (int k = 0; k < FILL_N; k++)
					issue_word(CMD_WRITE, CHAN_W'(c), SAMPLE_BITS'($urandom),
						FL_W'($urandom), LEVEL_W'(l), NODE_W'(fill_nodes[k]),
						rand_offset(), 1'b0, '0);

		// Directed table.
		send_idle_pct = 20;
		stall_pct     = 20;
		for (i = 0; i < DIR_N; i++) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG)
				set_register(row.ridx, row.e_val);
			else
				issue_word(row.cmd, row.chan, row.pixel, row.level, row.e_lv, row.e_nd,
					row.e_val, row.typed, row.exp_sample);
		end

		// Random segments, each under its own settings; the last one without idling.
		for (seg = 0; seg < SEG_COUNT; seg++) begin
			en = 1'b1;
			case (seg)
				0: zval = 16'h0000;
				1: zval = CFG_DATA_W'($urandom_range(400)) - CFG_DATA_W'(200);
				2: zval = 16'h8000;
				3: begin
					en   = 1'b0;
					zval = CFG_DATA_W'($urandom);
				end
				4: zval = 16'h7FFF;
				5: zval = CFG_DATA_W'($urandom);
				default: zval = CFG_DATA_W'($urandom_range(60)) - CFG_DATA_W'(30);
			endcase
			set_register(REG_ENABLE, CFG_DATA_W'(en));
			set_register(REG_ZERO, zval);
			if (seg == SEG_COUNT - 1) begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end else begin
				pick = $urandom_range(2);
				send_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
				pick = $urandom_range(2);
				stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
			end
			for (i = 0; i < SEG_WORDS; i++) begin
				cmd  = ($urandom_range(99) < 30) ? CMD_WRITE : CMD_SAMPLE;
				chan = ($urandom_range(9) == 0) ? 2'd3 : CHAN_W'($urandom_range(2));
				pick = $urandom_range(9);
				// Samples stay on node pairs that are filled; writes mostly hit those nodes.
				pixel = (pick == 0) ? '0 : (pick == 1) ? '1
					: {NODE_W'(pair_bases[$urandom_range(BASE_N - 1)]), FRAC_W'($urandom)};
				level = ($urandom_range(9) == 0) ? '1 : FL_W'($urandom);
				enode = ($urandom_range(9) == 0) ? NODE_W'($urandom)
					: NODE_W'(fill_nodes[$urandom_range(FILL_N - 1)]);
				issue_word(cmd, chan, pixel, level, LEVEL_W'($urandom), enode,
					rand_offset(), 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		// Drain, then keep watching for any stray word.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH * 4) @(posedge clk);

		$display("Sent %0d sample words and %0d table writes over %0d register writes.",
			samples_sent, words_written, reg_writes);
		$display("Checked %0d results, %0d mismatches, in %0d cycles.",
			results_seen, mismatch_count, cycle_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/lbpo_pkg.sv
hdl/lut_bilinear_pixel_offset_top.sv
bench/lut_bilinear_pixel_offset_top_tb.sv
